>>> design/smx_pkg.sv
// Shared types, constants and the exponent table for the softmax vector unit.
`default_nettype none
package smx_pkg;

  localparam int MaxLenDefault = 64;
  localparam int ExpTableBitsDefault = 8;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [23:0] SumMax = 24'hFFFFFF;

  typedef struct packed {
    logic signed [15:0] value;
    logic signed [15:0] loss;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               last_out;
    logic               overflow;
  } out_item_t;

  // Job handed from the loader to the compute engine once a vector closes.
  typedef struct packed {
    logic [10:0]        count;
    logic signed [15:0] vmax;
    logic               overflow;
  } job_t;

  // Fractional powers 2^(-2^-(j+1)) in Q0.30.
  function automatic logic [29:0] pow2_entry(input logic [3:0] j);
    logic [29:0] r;
    begin
      case (j)
        4'd0:  r = 30'd759250125;
        4'd1:  r = 30'd902905656;
        4'd2:  r = 30'd984625594;
        4'd3:  r = 30'd1028218693;
        4'd4:  r = 30'd1050733751;
        4'd5:  r = 30'd1062175491;
        4'd6:  r = 30'd1067942999;
        4'd7:  r = 30'd1070838486;
        4'd8:  r = 30'd1072289172;
        4'd9:  r = 30'd1073015247;
        4'd10: r = 30'd1073378473;
        4'd11: r = 30'd1073560133;
        default: r = 30'd0;
      endcase
      return r;
    end
  endfunction

endpackage
`default_nettype wire

>>> design/softmax_vector_unit.sv
// Top level of the softmax vector unit.
//   channel  | handshake        | payload
//   input    | push / full      | in_item  (value, loss, last)
//   result   | pop / empty      | out_item (result, last_out, overflow)
//   config   | mode_we          | mode_wdata (mode)
// Loading takes one item per cycle while full is low; the closing item registers a job for the engine.
// The sum pass runs each element through the exp unit; the emit pass runs each
// element through the exp unit and the divider, plus the gradient states in backward mode,
// using the shared exp unit and the 41-step divider, plus any wait for pop.
// Reset is synchronous; mode clears to forward.
// full stays high from the closing item until the last result of the vector is popped.
`default_nettype none
module softmax_vector_unit #(
  parameter int MAX_LEN = smx_pkg::MaxLenDefault,
  parameter int EXP_TABLE_BITS = smx_pkg::ExpTableBitsDefault
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push,
  output logic                    full,
  input  wire smx_pkg::in_item_t  in_item,
  output logic                    empty,
  input  wire logic               pop,
  output smx_pkg::out_item_t      out_item,
  input  wire logic               mode_we,
  input  wire logic               mode_wdata
);
  logic                       mode;
  logic                       job_valid;
  logic                       job_take;
  smx_pkg::job_t              job;
  logic [$clog2(MAX_LEN)-1:0] rd_addr;
  logic signed [15:0]         rd_value;
  logic signed [15:0]         rd_loss;
  logic                       out_valid;
  logic                       engine_busy;

  always_ff @(posedge clk) begin
    if (rst) mode <= 1'b0;
    else if (mode_we) mode <= mode_wdata;
  end

  // One vector in flight: stores are shared by loader and engine.
  always_ff @(posedge clk) begin
    if (rst) engine_busy <= 1'b0;
    else if (out_valid && pop && out_item.last_out) engine_busy <= 1'b0;
    else if (job_take) engine_busy <= 1'b1;
  end

  assign full  = job_valid || engine_busy;
  assign empty = !out_valid;

  smx_front #(.MAX_LEN(MAX_LEN)) u_front (
    .clk(clk), .rst(rst), .accept(push && !full), .item(in_item),
    .job_valid(job_valid), .job(job), .job_take(job_take),
    .rd_addr(rd_addr), .rd_value(rd_value), .rd_loss(rd_loss)
  );

  smx_engine #(.MAX_LEN(MAX_LEN), .EXP_TABLE_BITS(EXP_TABLE_BITS)) u_engine (
    .clk(clk), .rst(rst), .mode(mode), .job_valid(job_valid), .job(job),
    .job_take(job_take), .rd_addr(rd_addr), .rd_value(rd_value), .rd_loss(rd_loss),
    .out_valid(out_valid), .out_item(out_item), .out_take(pop)
  );
endmodule
`default_nettype wire

>>> design/smx_exp.sv
// Iterative exponential unit: e = exp(-m) in unsigned Q1.16, one table step a cycle.
`default_nettype none
module smx_exp #(
  parameter int EXP_TABLE_BITS = smx_pkg::ExpTableBitsDefault
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [15:0] m,
  output logic             done,
  output logic [16:0]      e
);
  localparam int StepW = $clog2(EXP_TABLE_BITS + 1);

  logic [1:0]       phase;
  logic [StepW-1:0] step;
  logic [32:0]      t;
  logic [31:0]      acc;
  logic [59:0]      prod;
  logic [4:0]       k;
  logic [3:0]       tab_idx;
  logic [31:0]      round_add;
  logic [31:0]      shifted;

  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhStep = 2'd2;
  localparam logic [1:0] PhOut  = 2'd3;

  assign tab_idx = 4'(step);
  assign k = t[28:24];
  // Step multiply: 31-bit acc by 30-bit table entry.
  assign prod = 60'(acc[30:0]) * 60'(smx_pkg::pow2_entry(tab_idx));
  assign round_add = (t[32:24] >= 9'd17) ? 32'd0 : (32'd1 << (5'd13 + k));
  assign shifted = (acc + round_add) >> (5'd14 + k);

  // Sequencer over the table bits.
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      phase <= PhIdle;
    end else begin
      case (phase)
        PhIdle: begin
          if (start) begin
            t     <= 33'(m) * 33'(smx_pkg::Log2eQ16);
            acc   <= 32'd1 << 30;
            step  <= '0;
            phase <= PhStep;
          end
        end
        PhStep: begin
          if (step == StepW'(EXP_TABLE_BITS)) begin
            phase <= PhOut;
          end else begin
            if (t[5'd23 - 5'(step)]) begin
              acc <= 32'((prod + 60'd536870912) >> 30);
            end
            step <= step + 1'b1;
          end
        end
        PhOut: begin
          e     <= (t[32:24] >= 9'd17) ? 17'd0 : 17'(shifted);
          done  <= 1'b1;
          phase <= PhIdle;
        end
        default: phase <= PhIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/smx_div.sv
// Restoring divider: q = num / den, one quotient bit a cycle.
`default_nettype none
module smx_div (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [40:0] num,
  input  wire logic [23:0] den,
  output logic             done,
  output logic [17:0]      q
);
  logic        busy;
  logic [5:0]  cnt;
  logic [40:0] n;
  logic [24:0] rem;
  logic [24:0] trial;
  logic [40:0] quo;

  assign trial = {rem[23:0], n[40]} - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      n    <= num;
      rem  <= '0;
      quo  <= '0;
      cnt  <= 6'd41;
    end else if (busy) begin
      n <= {n[39:0], 1'b0};
      if (!trial[24]) begin
        rem <= trial;
        quo <= {quo[39:0], 1'b1};
      end else begin
        rem <= {rem[23:0], n[40]};
        quo <= {quo[39:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == 6'd1) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  assign q = quo[17:0];
endmodule
`default_nettype wire

>>> design/smx_engine.sv
// Back part: exp pass for the sum, then a second exp pass with divide, the gradient in backward mode, and emit.
`default_nettype none
module smx_engine #(
  parameter int MAX_LEN = smx_pkg::MaxLenDefault,
  parameter int EXP_TABLE_BITS = smx_pkg::ExpTableBitsDefault
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       mode,
  input  wire logic                       job_valid,
  input  wire smx_pkg::job_t              job,
  output logic                            job_take,
  output logic [$clog2(MAX_LEN)-1:0]      rd_addr,
  input  wire logic signed [15:0]         rd_value,
  input  wire logic signed [15:0]         rd_loss,
  output logic                            out_valid,
  output smx_pkg::out_item_t              out_item,
  input  wire logic                       out_take
);
  localparam int AW = $clog2(MAX_LEN);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StExp   = 3'd2;
  localparam logic [2:0] StDiv   = 3'd3;
  localparam logic [2:0] StGrad  = 3'd4;
  localparam logic [2:0] StGrad2 = 3'd5;
  localparam logic [2:0] StEmit  = 3'd6;

  logic [2:0]         state;
  logic               pass2;
  logic [10:0]        idx;
  smx_pkg::job_t      cur;
  logic [23:0]        sum;
  logic               exp_start;
  logic               exp_done;
  logic [16:0]        e_val;
  logic               div_start;
  logic               div_done;
  logic [17:0]        a;
  logic [33:0]        g_prod;
  logic [16:0]        g;
  logic signed [15:0] loss_q;
  logic signed [34:0] p;
  logic [24:0]        sum_add;
  logic [15:0]        mdiff;

  assign rd_addr = idx[AW-1:0];
  assign mdiff = 16'(cur.vmax - rd_value);
  assign sum_add = 25'(sum) + 25'(e_val);

  smx_exp #(.EXP_TABLE_BITS(EXP_TABLE_BITS)) u_exp (
    .clk(clk), .rst(rst), .start(exp_start), .m(mdiff), .done(exp_done), .e(e_val)
  );

  smx_div u_div (
    .clk(clk), .rst(rst), .start(div_start),
    .num({8'd0, e_val, 16'd0} + 41'(sum >> 1)), .den(sum),
    .done(div_done), .q(a)
  );

  // Per element sequencer.
  always_ff @(posedge clk) begin
    exp_start <= 1'b0;
    div_start <= 1'b0;
    job_take  <= 1'b0;
    if (rst) begin
      state     <= StIdle;
      out_valid <= 1'b0;
    end else begin
      case (state)
        StIdle: begin
          if (job_valid && !job_take) begin
            cur      <= job;
            job_take <= 1'b1;
            sum      <= '0;
            idx      <= '0;
            pass2    <= 1'b0;
            state    <= StRead;
          end
        end
        StRead: begin
          // Read data of the stores is registered, so the exp unit starts from this state.
          exp_start <= 1'b1;
          state     <= StExp;
        end
        StExp: begin
          if (exp_done) begin
            loss_q <= rd_loss;
            if (!pass2) begin
              sum <= (sum_add > 25'(smx_pkg::SumMax)) ? smx_pkg::SumMax : sum_add[23:0];
              if (idx + 11'd1 == cur.count) begin
                idx   <= '0;
                pass2 <= 1'b1;
              end else begin
                idx <= idx + 11'd1;
              end
              state <= StRead;
            end else begin
              div_start <= 1'b1;
              state     <= StDiv;
            end
          end
        end
        StDiv: begin
          if (div_done) begin
            if (mode) begin
              g_prod <= 34'(a) * 34'(18'd65536 - a);
              state  <= StGrad;
            end else begin
              out_item.result <= 32'(a);
              state           <= StEmit;
            end
          end
        end
        StGrad: begin
          g     <= 17'((g_prod + 34'd32768) >> 16);
          state <= StGrad2;
        end
        StGrad2: begin
          p     <= 35'(loss_q) * $signed({18'd0, g}) + 35'sd128;
          state <= StEmit;
          pass2 <= 1'b1;
        end
        StEmit: begin
          if (!out_valid) begin
            if (mode) out_item.result <= 32'(p >>> 8);
            out_item.last_out <= (idx + 11'd1 == cur.count);
            out_item.overflow <= cur.overflow;
            out_valid <= 1'b1;
          end else if (out_take) begin
            out_valid <= 1'b0;
            if (out_item.last_out) begin
              state <= StIdle;
            end else begin
              idx   <= idx + 11'd1;
              state <= StRead;
            end
          end
        end
        default: state <= StIdle;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> design/smx_front.sv
// Front part: stores elements, tracks the maximum and closes vectors into jobs.
`default_nettype none
module smx_front #(
  parameter int MAX_LEN = smx_pkg::MaxLenDefault
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   accept,
  input  wire smx_pkg::in_item_t      item,
  output logic                        job_valid,
  output smx_pkg::job_t               job,
  input  wire logic                   job_take,
  input  wire logic [$clog2(MAX_LEN)-1:0] rd_addr,
  output logic signed [15:0]          rd_value,
  output logic signed [15:0]          rd_loss
);
  localparam int AW = $clog2(MAX_LEN);

  logic signed [15:0] value_store [MAX_LEN];
  logic signed [15:0] loss_store [MAX_LEN];
  logic [10:0]        count;
  logic signed [15:0] vmax;
  logic               ovf;
  logic               room;

  assign room = count < 11'(MAX_LEN);

  always_ff @(posedge clk) begin
    if (accept && room) begin
      value_store[count[AW-1:0]] <= item.value;
      loss_store[count[AW-1:0]]  <= item.loss;
    end
    rd_value <= value_store[rd_addr];
    rd_loss  <= loss_store[rd_addr];
  end

  // Vector accumulation; one closed job held until the engine takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      vmax      <= -16'sd32768;
      ovf       <= 1'b0;
      job_valid <= 1'b0;
    end else begin
      if (job_take) job_valid <= 1'b0;
      if (accept) begin
        if (item.last) begin
          job.count    <= room ? count + 11'd1 : count;
          job.vmax     <= (room && item.value > vmax) ? item.value : vmax;
          job.overflow <= ovf || !room;
          job_valid    <= 1'b1;
          count        <= '0;
          vmax         <= -16'sd32768;
          ovf          <= 1'b0;
        end else if (room) begin
          count <= count + 11'd1;
          if (item.value > vmax) vmax <= item.value;
        end else begin
          ovf <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> design/smx_checker.sv
// Port-level checker for the softmax vector unit and its bind.
`default_nettype none
module smx_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               push,
  input wire logic               full,
  input wire logic               empty,
  input wire logic               pop,
  input wire smx_pkg::in_item_t  in_item,
  input wire smx_pkg::out_item_t out_item
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(out_item))
    else $error("result changed while stalled");
  a_last_full: assert property (@(posedge clk) disable iff (rst)
    push && !full && in_item.last |=> full)
    else $error("closing item did not block input");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> empty)
    else $error("results present after reset");
  a_no_out_while_open: assert property (@(posedge clk) disable iff (rst)
    !full |-> empty)
    else $error("result shown while loading");
endmodule

bind softmax_vector_unit smx_checker u_chk (
  .clk(clk), .rst(rst), .push(push), .full(full), .empty(empty), .pop(pop),
  .in_item(in_item), .out_item(out_item)
);
`default_nettype wire
